### rtl/steq_pkg.sv
// Package with the shared types and constants of the sorted timer event queue.
`default_nettype none

package steq_pkg;

  typedef struct packed {
    logic [63:0] deadline;
    logic [7:0]  handler;
    logic [63:0] arg;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_WALK,
    ST_PLACE,
    ST_DEQ_HEAD,
    ST_DEQ_NEXT,
    ST_DONE
  } state_t;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [31:0] TPS_RESET = 32'd62500000;

endpackage

`default_nettype wire

### rtl/steq_ram.sv
// Event store memory with one write port and one registered read port.
`default_nettype none

module steq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire steq_pkg::entry_t  wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output steq_pkg::entry_t       rd_data
);

  steq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/sorted_timer_event_queue.sv
// Top level of the sorted timer event queue.
//
// The input channel carries one command word: an add (opcode 0) or a dequeue
// of the head on timer expiry (opcode 1). Each command gives exactly one
// result word on the output channel. Both channels move a word at an edge
// where valid is high and stall is low.
// Events live in a circular buffer in one memory, ordered by deadline from
// the head pointer. An add works in steps: one state multiplies delay by
// ticks per second, one adds now, and then the insert walks back from the
// tail one entry per cycle, moving each later entry up by one, so the walk
// length is set by the number of queued events.
// A dequeue reads the memory twice, for the head and the entry after it, and
// a dequeue of an empty queue goes straight to the last state. One command is
// in work at a time; the result waits in an output register while the
// receiver stalls. The next command may be accepted meanwhile, but its own
// result holds in the last state, with in_stall high, until that register is
// free. Reset empties the queue and loads ticks_per_second with 62500000; the
// memory itself is not cleared, since only queued entries are ever used.
// The configuration register is written through cfg_wen and cfg_wdata.
`default_nettype none

module sorted_timer_event_queue #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wen,
  input  wire logic [31:0]   cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          opcode,
  input  wire logic [63:0]   now,
  input  wire logic [31:0]   delay_seconds,
  input  wire logic [7:0]    handler_id,
  input  wire logic [63:0]   handler_arg,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         status,
  output logic               fired,
  output logic [7:0]         fired_handler,
  output logic [63:0]        fired_arg,
  output logic [63:0]        fired_deadline,
  output logic               reload_valid,
  output logic [63:0]        reload_ticks,
  output logic               timer_enable,
  output logic [CW-1:0]      queued_count
);

  localparam logic [AW:0]   DEPTH_L = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  steq_pkg::state_t state, state_next;

  logic [31:0]   tps;
  logic          op;
  logic [63:0]   now_q;
  logic [31:0]   delay_q;
  logic [7:0]    hid_q;
  logic [63:0]   harg_q;
  logic [63:0]   prod;
  logic [63:0]   dl;
  logic [63:0]   head_deadline;
  logic [AW-1:0] head_ptr;
  logic [CW-1:0] count;
  logic [AW-1:0] widx;
  logic [1:0]    cur_status;
  logic          fire_hit;
  logic [7:0]    fire_handler;
  logic [63:0]   fire_arg;
  logic [63:0]   fire_deadline;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  steq_pkg::entry_t wr_data;
  logic [AW-1:0]    rd_addr;
  steq_pkg::entry_t rd_data;

  logic [63:0]   dl_sum;
  logic [CW-1:0] count_m1;
  logic          shift_up;
  logic          out_free;
  logic          accept;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= DEPTH_L) begin
      sum = sum - DEPTH_L;
    end
    return sum[AW-1:0];
  endfunction

  assign dl_sum   = now_q + prod;
  assign count_m1 = count - 1'b1;
  assign shift_up = rd_data.deadline > dl;
  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  steq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      steq_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (opcode == steq_pkg::OP_ADD) begin
            state_next = steq_pkg::ST_MUL;
          end else if (count == '0) begin
            state_next = steq_pkg::ST_DONE;
          end else begin
            state_next = steq_pkg::ST_DEQ_HEAD;
          end
        end
      end
      steq_pkg::ST_MUL: state_next = steq_pkg::ST_ADD;
      steq_pkg::ST_ADD: begin
        if (count == DEPTH_C || count == '0) begin
          state_next = steq_pkg::ST_DONE;
        end else begin
          state_next = steq_pkg::ST_WALK;
        end
      end
      steq_pkg::ST_WALK: begin
        if (!shift_up) begin
          state_next = steq_pkg::ST_DONE;
        end else if (widx == '0) begin
          state_next = steq_pkg::ST_PLACE;
        end
      end
      steq_pkg::ST_PLACE:    state_next = steq_pkg::ST_DONE;
      steq_pkg::ST_DEQ_HEAD: state_next = steq_pkg::ST_DEQ_NEXT;
      steq_pkg::ST_DEQ_NEXT: state_next = steq_pkg::ST_DONE;
      steq_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = steq_pkg::ST_IDLE;
        end
      end
      default: state_next = steq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != steq_pkg::ST_IDLE);
    wr_en    = 1'b0;
    wr_addr  = phys(head_ptr, '0);
    wr_data  = '{deadline: dl, handler: hid_q, arg: harg_q};
    rd_addr  = phys(head_ptr, '0);
    case (state)
      steq_pkg::ST_ADD: begin
        wr_data = '{deadline: dl_sum, handler: hid_q, arg: harg_q};
        wr_en   = (count == '0);
        rd_addr = phys(head_ptr, count_m1[AW-1:0]);
      end
      steq_pkg::ST_WALK: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_ptr, AW'(widx + 1'b1));
        if (shift_up) begin
          wr_data = rd_data;
        end
        rd_addr = phys(head_ptr, AW'(widx - 1'b1));
      end
      steq_pkg::ST_PLACE: begin
        wr_en = 1'b1;
      end
      steq_pkg::ST_DEQ_HEAD: begin
        rd_addr = phys(head_ptr, AW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= steq_pkg::ST_IDLE;
      tps       <= steq_pkg::TPS_RESET;
      count     <= '0;
      head_ptr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        tps <= cfg_wdata;
      end
      if (state == steq_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        steq_pkg::ST_ADD: begin
          if (count == '0) begin
            count <= CW'(1);
          end
        end
        steq_pkg::ST_WALK: begin
          if (!shift_up) begin
            count <= count + 1'b1;
          end
        end
        steq_pkg::ST_PLACE: count <= count + 1'b1;
        steq_pkg::ST_DEQ_HEAD: begin
          head_ptr <= phys(head_ptr, AW'(1));
          count    <= count_m1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      steq_pkg::ST_IDLE: begin
        if (accept) begin
          op         <= opcode;
          now_q      <= now;
          delay_q    <= delay_seconds;
          hid_q      <= handler_id;
          harg_q     <= handler_arg;
          fire_hit   <= 1'b0;
          cur_status <= (opcode == steq_pkg::OP_DEQ && count == '0) ? steq_pkg::STATUS_EMPTY
                                                                      : steq_pkg::STATUS_OK;
        end
      end
      steq_pkg::ST_MUL: prod <= 64'(delay_q) * 64'(tps);
      steq_pkg::ST_ADD: begin
        dl   <= dl_sum;
        widx <= count_m1[AW-1:0];
        if (count == DEPTH_C) begin
          cur_status <= steq_pkg::STATUS_FULL;
        end else if (count == '0) begin
          head_deadline <= dl_sum;
        end
      end
      steq_pkg::ST_WALK: widx <= widx - 1'b1;
      steq_pkg::ST_PLACE: head_deadline <= dl;
      steq_pkg::ST_DEQ_HEAD: begin
        fire_hit      <= 1'b1;
        fire_handler  <= rd_data.handler;
        fire_arg      <= rd_data.arg;
        fire_deadline <= rd_data.deadline;
      end
      steq_pkg::ST_DEQ_NEXT: head_deadline <= rd_data.deadline;
      steq_pkg::ST_DONE: begin
        if (out_free) begin
          status         <= cur_status;
          fired          <= fire_hit;
          fired_handler  <= fire_hit ? fire_handler : '0;
          fired_arg      <= fire_hit ? fire_arg : '0;
          fired_deadline <= fire_hit ? fire_deadline : '0;
          reload_valid   <= (cur_status == steq_pkg::STATUS_OK) && (count != '0);
          reload_ticks   <= ((cur_status == steq_pkg::STATUS_OK) && (count != '0))
                            ? head_deadline - now_q : '0;
          timer_enable   <= (count != '0);
          queued_count   <= count;
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("Pending count exceeds the queue depth.");

  a_reload_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && reload_valid |-> timer_enable && status == steq_pkg::STATUS_OK)
    else $error("Reload requested without a pending event or with an error status.");

  a_walk_room: assert property (@(posedge clk) disable iff (rst)
    state == steq_pkg::ST_WALK |-> count != '0 && count < DEPTH_C && op == steq_pkg::OP_ADD)
    else $error("Insert walk started on an empty or full queue.");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> status == steq_pkg::STATUS_OK)
    else $error("Fired event reported with an error status.");

endmodule

`default_nettype wire
